@@ src/csc_pkg.sv @@
// Shared constants, types and a helper function of the closed syncmer classifier.
package csc_pkg;

   localparam int MAX_K      = 32;
   localparam int NUM_POS    = MAX_K;
   localparam int POS_W      = $clog2(NUM_POS);
   localparam int TREE_DEPTH = $clog2(NUM_POS);
   localparam int NUM_NODES  = 2 * NUM_POS - 1;
   localparam int LEAF_BASE  = NUM_POS - 1;
   localparam int LEN_W      = 6;
   localparam int WORD_W     = 64;
   localparam int COUNT_W    = 64;
   localparam int CSR_IDX_W  = 1;

   // Result tdata layout, lowest bit first.
   localparam int RSP_CLOSED_LSB = 0;
   localparam int RSP_POS_LSB    = RSP_CLOSED_LSB + 1;
   localparam int RSP_SMER_LSB   = RSP_POS_LSB + POS_W;
   localparam int RSP_COUNT_LSB  = RSP_SMER_LSB + WORD_W;
   localparam int RSP_USED_W     = RSP_COUNT_LSB + COUNT_W;
   localparam int RSP_DATA_W     = ((RSP_USED_W + 7) / 8) * 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KMER_LENGTH = 1'b0,
      CSR_SMER_LENGTH = 1'b1
   } csr_index_type;

   // One s-mer candidate: value, start position, and whether it lies inside the k-mer.
   typedef struct packed {
      logic              ok;
      logic [POS_W-1:0]  pos;
      logic [WORD_W-1:0] val;
   } cand_type;

   // Per-item side information that travels along the tree.
   typedef struct packed {
      logic             err;
      logic [POS_W-1:0] last;
   } meta_type;

   // Mask of the low 2*s bits of a word.
   function automatic logic [WORD_W-1:0] smer_mask(input logic [LEN_W-1:0] s);
      logic [LEN_W:0] nbits;
      nbits = {s, 1'b0};
      if (nbits >= (LEN_W + 1)'(WORD_W)) begin
         smer_mask = '1;
      end else begin
         smer_mask = (WORD_W'(1) << nbits) - WORD_W'(1);
      end
   endfunction

endpackage

@@ src/csc_min_node.sv @@
// One compare-select node of the minimum tree; the lower-position input wins ties.
module csc_min_node (
   input  csc_pkg::cand_type lo_cand,
   input  csc_pkg::cand_type hi_cand,
   output csc_pkg::cand_type win_cand
);

   logic pick_hi;

   assign pick_hi  = hi_cand.ok && (!lo_cand.ok || (hi_cand.val < lo_cand.val));
   assign win_cand = pick_hi ? hi_cand : lo_cand;

endmodule

@@ src/csc_leaf_gen.sv @@
// Splits a k-mer word into its s-mer candidates and checks the configuration.
module csc_leaf_gen (
   input  logic [csc_pkg::WORD_W-1:0]                   kmer_word,
   input  logic [csc_pkg::LEN_W-1:0]                    kmer_length,
   input  logic [csc_pkg::LEN_W-1:0]                    smer_length,
   output csc_pkg::cand_type [csc_pkg::NUM_POS-1:0]     leaves,
   output csc_pkg::meta_type                            meta
);

   logic [csc_pkg::WORD_W-1:0] smask;
   logic [csc_pkg::LEN_W-1:0]  last_pos;

   assign smask    = csc_pkg::smer_mask(smer_length);
   assign last_pos = kmer_length - smer_length;

   assign meta.err  = (kmer_length == '0) || (smer_length == '0) ||
                      (kmer_length > csc_pkg::LEN_W'(csc_pkg::MAX_K)) ||
                      (smer_length > kmer_length);
   assign meta.last = last_pos[csc_pkg::POS_W-1:0];

   // Bits above 2k never reach a candidate that lies inside the k-mer, so no word mask.
   for (genvar p = 0; p < csc_pkg::NUM_POS; p++) begin : g_leaf
      assign leaves[p].val = (kmer_word >> (2 * p)) & smask;
      assign leaves[p].pos = csc_pkg::POS_W'(p);
      assign leaves[p].ok  = (csc_pkg::LEN_W'(p) <= last_pos);
   end

endmodule

@@ src/closed_syncmer_classifier.sv @@
// A result passes the input register, the tree levels from leaves to root, and the result register.
// The registered minimum tree takes one item per cycle while rsp_tready does not hold the output.
// Each stage advances whenever its successor is empty or moving, so bubbles are squeezed out.
// Reset (synchronous, active high) empties the pipeline, clears the syncmer count and
// restores kmer_length to 16 and smer_length to 8.
module closed_syncmer_classifier (
   input  logic                             clock,
   input  logic                             reset,
   // Input stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [csc_pkg::WORD_W-1:0]       req_tdata,   // [63:0] kmer_word
   // Result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] is_closed_syncmer, [5:1] min_position, [69:6] min_smer,
   // [133:70] syncmer_count, [135:134] zero
   output logic [csc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tuser,   // [0] config_error
   // Register write port
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [csc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [csc_pkg::LEN_W-1:0]        csr_data
);

   localparam int TD = csc_pkg::TREE_DEPTH;

   // Configuration registers. Writes are always taken; software must write only while idle.
   logic [csc_pkg::LEN_W-1:0] kmer_len_ff;
   logic [csc_pkg::LEN_W-1:0] smer_len_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_len_ff <= csc_pkg::LEN_W'(16);
         smer_len_ff <= csc_pkg::LEN_W'(8);
      end else if (csr_valid) begin
         unique case (csc_pkg::csr_index_type'(csr_index))
            csc_pkg::CSR_KMER_LENGTH: kmer_len_ff <= csr_data;
            csc_pkg::CSR_SMER_LENGTH: smer_len_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Pipeline control. Stage order: input register, tree depth TD (leaves) down to
   // depth 0 (root), then the result register. Each stage loads when it is empty
   // or when the stage after it is loading.
   logic                    in_v_ff;
   logic [csc_pkg::WORD_W-1:0] in_word_ff;
   logic [TD:0]             tv_ff;
   csc_pkg::meta_type       meta_ff [TD+1];
   csc_pkg::cand_type       node_ff [csc_pkg::NUM_NODES];
   logic                    rsp_v_ff;
   logic                    en_out;
   logic [TD:0]             en_t;
   logic                    en_in;

   always_comb begin
      en_out  = !rsp_v_ff || rsp_tready;
      en_t[0] = !tv_ff[0] || en_out;
      for (int d = 1; d <= TD; d++) begin
         en_t[d] = !tv_ff[d] || en_t[d-1];
      end
      en_in = !in_v_ff || en_t[TD];
   end

   assign req_tready = en_in;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (en_in) begin
         in_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_in && req_tvalid) begin
         in_word_ff <= req_tdata;
      end
   end

   // Candidate extraction feeds the leaf row of the tree.
   csc_pkg::cand_type [csc_pkg::NUM_POS-1:0] leaves;
   csc_pkg::meta_type                        leaf_meta;

   csc_leaf_gen u_leaf_gen (
      .kmer_word   (in_word_ff),
      .kmer_length (kmer_len_ff),
      .smer_length (smer_len_ff),
      .leaves      (leaves),
      .meta        (leaf_meta)
   );

   // Tree valid bits and side information, one entry per depth.
   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff <= '0;
      end else begin
         if (en_t[TD]) begin
            tv_ff[TD] <= in_v_ff;
         end
         for (int d = 0; d < TD; d++) begin
            if (en_t[d]) begin
               tv_ff[d] <= tv_ff[d+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_t[TD] && in_v_ff) begin
         meta_ff[TD] <= leaf_meta;
      end
      for (int d = 0; d < TD; d++) begin
         if (en_t[d] && tv_ff[d+1]) begin
            meta_ff[d] <= meta_ff[d+1];
         end
      end
   end

   // Minimum tree in heap order: node n has children 2n+1 and 2n+2, the leaf for
   // position p is node LEAF_BASE+p, and every node is a register. The left child
   // always covers lower positions, which gives the lowest position on a tie.
   for (genvar n = 0; n < csc_pkg::NUM_NODES; n++) begin : g_node
      localparam int D = $clog2(n + 2) - 1;
      if (n >= csc_pkg::LEAF_BASE) begin : g_leaf
         always_ff @(posedge clock) begin
            if (en_t[TD] && in_v_ff) begin
               node_ff[n] <= leaves[n - csc_pkg::LEAF_BASE];
            end
         end
      end else begin : g_inner
         csc_pkg::cand_type win;

         csc_min_node u_min_node (
            .lo_cand  (node_ff[2*n+1]),
            .hi_cand  (node_ff[2*n+2]),
            .win_cand (win)
         );

         always_ff @(posedge clock) begin
            if (en_t[D] && tv_ff[D+1]) begin
               node_ff[n] <= win;
            end
         end
      end
   end

   // Classification and the saturating syncmer count, taken in order at the root.
   logic [csc_pkg::COUNT_W-1:0] total_ff;
   logic [csc_pkg::COUNT_W-1:0] total_in;
   logic                        hit;
   logic                        root_err;

   assign root_err = meta_ff[0].err;
   assign hit      = !root_err &&
                     ((node_ff[0].pos == '0) || (node_ff[0].pos == meta_ff[0].last));

   always_comb begin
      total_in = total_ff;
      if (en_out && tv_ff[0] && hit && (total_ff != '1)) begin
         total_in = total_ff + csc_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   // Result register. It keeps a finished result until the transfer while the
   // stages behind it keep filling.
   logic                        rsp_closed_ff;
   logic [csc_pkg::POS_W-1:0]   rsp_pos_ff;
   logic [csc_pkg::WORD_W-1:0]  rsp_smer_ff;
   logic [csc_pkg::COUNT_W-1:0] rsp_count_ff;
   logic                        rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (en_out) begin
         rsp_v_ff <= tv_ff[0];
      end
   end

   // Under a configuration error only the unchanged count is reported.
   always_ff @(posedge clock) begin
      if (en_out && tv_ff[0]) begin
         rsp_closed_ff <= hit;
         rsp_pos_ff    <= root_err ? '0 : node_ff[0].pos;
         rsp_smer_ff   <= root_err ? '0 : node_ff[0].val;
         rsp_count_ff  <= total_in;
         rsp_err_ff    <= root_err;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tuser  = rsp_err_ff;
   assign rsp_tdata  = {{(csc_pkg::RSP_DATA_W - csc_pkg::RSP_USED_W){1'b0}},
                        rsp_count_ff, rsp_smer_ff, rsp_pos_ff, rsp_closed_ff};

`ifndef ASSERT_OFF
   // An error result carries no classification, position or s-mer.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && rsp_err_ff) |-> (!rsp_closed_ff && (rsp_pos_ff == '0) &&
                                    (rsp_smer_ff == '0)))
      else $error("error result carries nonzero payload");

   // A valid result whose minimum sits at position zero is always a closed syncmer.
   a_pos0_closed: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && !rsp_err_ff && (rsp_pos_ff == '0)) |-> rsp_closed_ff)
      else $error("minimum at position zero not flagged as closed syncmer");

   // The count only changes when an item leaves the root, and then by exactly one.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (total_ff != $past(total_ff))) |->
         ($past(en_out && tv_ff[0]) && (total_ff == $past(total_ff) + csc_pkg::COUNT_W'(1))))
      else $error("syncmer count changed unexpectedly");

   // A newly loaded result reports the count as it stands.
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(en_out && tv_ff[0])) |-> (rsp_count_ff == total_ff))
      else $error("reported count differs from running total");
`endif

endmodule
